// ----- rtl/core/hsirgbw_pkg.sv -----
// Package for the HSI to RGBW converter: types, constants and the gain table.
`default_nettype none
package hsirgbw_pkg;

	localparam int OUT_BITS  = 8;
	localparam int FRAC_BITS = 12;

	localparam int HUE_W   = 16;
	localparam int SI_IN_W = FRAC_BITS + 1;
	localparam int SI_W    = 2 * FRAC_BITS + 1;
	localparam int SIM_W   = SI_W + OUT_BITS;
	localparam int K_W     = 16;
	localparam int PROD_W  = SIM_W + K_W;
	localparam int LEAD_SH = 2 * FRAC_BITS + 15;
	localparam int WHT_SH  = 2 * FRAC_BITS;

	localparam int HUE_FULL    = 3600;
	localparam int GAIN_DEPTH  = HUE_FULL / 3;
	localparam int OFF_W       = $clog2(GAIN_DEPTH);
	localparam int HALF_SECTOR = GAIN_DEPTH / 2;

	localparam logic [SI_IN_W-1:0] ONE  = SI_IN_W'(1) << FRAC_BITS;
	localparam logic [K_W-1:0]     KONE = K_W'(32768);

	localparam int                 HQ_SH     = 4;
	localparam int                 HQ_W      = HUE_W - HQ_SH;
	localparam logic [9:0]         DIV75_MUL = 10'd874;
	localparam int                 DIV75_SH  = 16;
	localparam int                 Q_W       = 6;
	localparam logic [7:0]         DIV3_MUL  = 8'd171;
	localparam int                 DIV3_SH   = 9;
	localparam logic [OFF_W-1:0]   SECT_LEN  = OFF_W'(GAIN_DEPTH);

	localparam logic [63:0] PI_Q28 = 64'd843314857;

	typedef enum logic [1:0] {
		SEC_RG = 2'd0,
		SEC_GB = 2'd1,
		SEC_BR = 2'd2
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [SI_IN_W-1:0] saturation;
		logic [SI_IN_W-1:0] intensity;
	} hsi_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] red;
		logic [OUT_BITS-1:0] green;
		logic [OUT_BITS-1:0] blue;
		logic [OUT_BITS-1:0] white;
	} rgbw_t;

	typedef struct packed {
		logic [OFF_W-1:0]   offset;
		sector_t            sector;
		logic [SI_IN_W-1:0] sat;
		logic [SI_IN_W-1:0] inten;
	} st1_t;

	typedef struct packed {
		sector_t         sector;
		logic [SI_W-1:0] si;
		logic [SI_W-1:0] wi;
		logic [K_W-1:0]  gain;
	} st2_t;

	typedef logic [K_W-1:0] gain_tab_t [GAIN_DEPTH];

	function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
		case (k)
			1:       return t / 64'd2;
			2:       return t / 64'd12;
			3:       return t / 64'd30;
			4:       return t / 64'd56;
			5:       return t / 64'd90;
			6:       return t / 64'd132;
			7:       return t / 64'd182;
			8:       return t / 64'd240;
			9:       return t / 64'd306;
			10:      return t / 64'd380;
			default: return t;
		endcase
	endfunction

	function automatic longint cos_q28(input logic [63:0] a);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		int          k;
		x    = (a * PI_Q28 + 64'd900) / 64'd1800;
		x2   = (x * x) >> 28;
		term = 64'd1 << 28;
		sum  = longint'(term);
		for (k = 1; k <= 10; k++) begin
			term = taylor_div((term * x2) >> 28, k);
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return sum;
	endfunction

	function automatic logic [K_W-1:0] gain_q15(input int off);
		longint      c1;
		longint      c2;
		longint      s;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] quo;
		int          b;
		int          bit_i;
		b   = (off <= HALF_SECTOR) ? (HALF_SECTOR - off) : (off - HALF_SECTOR);
		c1  = cos_q28(64'(off));
		c2  = cos_q28(64'(b));
		s   = c1 + c2;
		if (s < 0)
			s = 0;
		if (c2 < 1)
			c2 = 1;
		den = 64'd3 * 64'(c2);
		num = (64'(s) << 15) + (den >> 1);
		rem = 64'd0;
		quo = 64'd0;
		for (bit_i = 63; bit_i >= 0; bit_i--) begin
			rem = {rem[62:0], num[bit_i]};
			if (rem >= den) begin
				rem        = rem - den;
				quo[bit_i] = 1'b1;
			end
		end
		if (quo > 64'(KONE))
			return KONE;
		return quo[K_W-1:0];
	endfunction

	function automatic gain_tab_t build_gain_tab();
		gain_tab_t tab;
		int        d;
		for (d = 0; d < GAIN_DEPTH; d++)
			tab[d] = gain_q15(d);
		return tab;
	endfunction

	localparam gain_tab_t GAIN_TAB = build_gain_tab();

endpackage
`default_nettype wire

// ----- rtl/core/hsirgbw_sector.sv -----
// Hue reduction to sector and offset, and clamping of saturation and intensity.
`default_nettype none
module hsirgbw_sector (
	input  hsirgbw_pkg::hsi_t color,
	output hsirgbw_pkg::st1_t st1
);

	logic [hsirgbw_pkg::HQ_W-1:0]          hq;
	logic [hsirgbw_pkg::HQ_W+9:0]          hq_prod;
	logic [hsirgbw_pkg::Q_W-1:0]           q;
	logic [hsirgbw_pkg::HUE_W:0]           q_base;
	logic [hsirgbw_pkg::HUE_W:0]           off_full;
	logic [hsirgbw_pkg::Q_W+7:0]           q3_prod;
	logic [hsirgbw_pkg::Q_W-1:0]           q3;
	logic [hsirgbw_pkg::Q_W+1:0]           sec_full;

	assign hq       = color.hue[hsirgbw_pkg::HUE_W-1:hsirgbw_pkg::HQ_SH];
	assign hq_prod  = (hsirgbw_pkg::HQ_W+10)'(hq) * (hsirgbw_pkg::HQ_W+10)'(hsirgbw_pkg::DIV75_MUL);
	assign q        = hq_prod[hsirgbw_pkg::DIV75_SH +: hsirgbw_pkg::Q_W];
	assign q_base   = (hsirgbw_pkg::HUE_W+1)'(q) *
		(hsirgbw_pkg::HUE_W+1)'(hsirgbw_pkg::SECT_LEN);
	assign off_full = (hsirgbw_pkg::HUE_W+1)'(color.hue) - q_base;

	assign q3_prod  = (hsirgbw_pkg::Q_W+8)'(q) * (hsirgbw_pkg::Q_W+8)'(hsirgbw_pkg::DIV3_MUL);
	assign q3       = (hsirgbw_pkg::Q_W)'(q3_prod >> hsirgbw_pkg::DIV3_SH);
	assign sec_full = (hsirgbw_pkg::Q_W+2)'(q) - (hsirgbw_pkg::Q_W+2)'(q3) * (hsirgbw_pkg::Q_W+2)'(3);

	always_comb begin
		st1.offset = off_full[hsirgbw_pkg::OFF_W-1:0];
		st1.sector = hsirgbw_pkg::sector_t'(sec_full[1:0]);
		st1.sat    = (color.saturation > hsirgbw_pkg::ONE) ? hsirgbw_pkg::ONE : color.saturation;
		st1.inten  = (color.intensity > hsirgbw_pkg::ONE) ? hsirgbw_pkg::ONE : color.intensity;
	end

endmodule
`default_nettype wire

// ----- rtl/core/hsirgbw_gain_rom.sv -----
// Gain table ROM indexed by hue offset within a sector, registered read.
`default_nettype none
module hsirgbw_gain_rom (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hsirgbw_pkg::OFF_W-1:0] addr,
	output logic [hsirgbw_pkg::K_W-1:0]   data
);

	always_ff @(posedge clk) begin
		if (en) begin
			data <= hsirgbw_pkg::GAIN_TAB[addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/hsirgbw_mix.sv -----
// Lead, trail and white products and routing of the shares to the color channels.
`default_nettype none
module hsirgbw_mix (
	input  hsirgbw_pkg::st2_t  st2,
	output hsirgbw_pkg::rgbw_t rgbw
);

	logic [hsirgbw_pkg::SIM_W-1:0]    sim;
	logic [hsirgbw_pkg::SIM_W-1:0]    wim;
	logic [hsirgbw_pkg::K_W-1:0]      rest;
	logic [hsirgbw_pkg::PROD_W-1:0]   lead_p;
	logic [hsirgbw_pkg::PROD_W-1:0]   trail_p;
	logic [hsirgbw_pkg::OUT_BITS-1:0] lead;
	logic [hsirgbw_pkg::OUT_BITS-1:0] trail;

	assign sim     = ((hsirgbw_pkg::SIM_W)'(st2.si) << hsirgbw_pkg::OUT_BITS) -
		(hsirgbw_pkg::SIM_W)'(st2.si);
	assign wim     = ((hsirgbw_pkg::SIM_W)'(st2.wi) << hsirgbw_pkg::OUT_BITS) -
		(hsirgbw_pkg::SIM_W)'(st2.wi);
	assign rest    = hsirgbw_pkg::KONE - st2.gain;
	assign lead_p  = (hsirgbw_pkg::PROD_W)'(sim) * (hsirgbw_pkg::PROD_W)'(st2.gain);
	assign trail_p = (hsirgbw_pkg::PROD_W)'(sim) * (hsirgbw_pkg::PROD_W)'(rest);
	assign lead    = lead_p[hsirgbw_pkg::LEAD_SH +: hsirgbw_pkg::OUT_BITS];
	assign trail   = trail_p[hsirgbw_pkg::LEAD_SH +: hsirgbw_pkg::OUT_BITS];

	always_comb begin
		rgbw.white = wim[hsirgbw_pkg::WHT_SH +: hsirgbw_pkg::OUT_BITS];
		rgbw.red   = '0;
		rgbw.green = '0;
		rgbw.blue  = '0;
		case (st2.sector)
			hsirgbw_pkg::SEC_RG: begin
				rgbw.red   = lead;
				rgbw.green = trail;
			end
			hsirgbw_pkg::SEC_GB: begin
				rgbw.green = lead;
				rgbw.blue  = trail;
			end
			default: begin
				rgbw.blue  = lead;
				rgbw.red   = trail;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/hsi_to_rgbw_converter_core.sv -----
// HSI to RGBW converter: three-stage pipeline with valid/stall handshake.
//
// Usage:
//   color_valid/color_stall/color carry HSI requests in (hue in tenths of a
//   degree, saturation and intensity in Q1.12); drive_valid/drive_stall/drive
//   carry the RGBW drive levels out. A request moves when valid is high and
//   stall is low at a rising clock edge.
//   drive_valid rises once the request has passed the stage 1, stage 2 and
//   stage 3 registers. One request is taken every cycle while the
//   output is not stalled.
//   Stage 1 reduces hue to sector and offset and clamps S and I. Stage 2 reads
//   the gain ROM and forms S*I and (1-S)*I. Stage 3 forms the lead, trail and
//   white products and routes them, and is the output register.
//   While drive_stall is high the output holds; empty stages behind it keep
//   filling, and color_stall rises only when all three stages hold requests.
//   arst_n clears all valid bits asynchronously; no request is in flight after
//   reset and the block is ready at once.
`default_nettype none
module hsi_to_rgbw_converter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               color_valid,
	output logic               color_stall,
	input  hsirgbw_pkg::hsi_t  color,
	output logic               drive_valid,
	input  logic               drive_stall,
	output hsirgbw_pkg::rgbw_t drive
);

	logic               en1;
	logic               en2;
	logic               en3;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	hsirgbw_pkg::st1_t  st1_d;
	hsirgbw_pkg::st1_t  st1_s1;
	hsirgbw_pkg::sector_t sector_s2;
	logic [hsirgbw_pkg::SI_W-1:0] si_s2;
	logic [hsirgbw_pkg::SI_W-1:0] wi_s2;
	logic [hsirgbw_pkg::K_W-1:0]  gain_s2;
	hsirgbw_pkg::st2_t  st2;
	hsirgbw_pkg::rgbw_t rgbw_d;
	hsirgbw_pkg::rgbw_t drive_s3;

	assign en3         = !valid_s3 || !drive_stall;
	assign en2         = !valid_s2 || en3;
	assign en1         = !valid_s1 || en2;
	assign color_stall = !en1;
	assign drive_valid = valid_s3;
	assign drive       = drive_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= color_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	hsirgbw_sector u_sector (
		.color (color),
		.st1   (st1_d)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			st1_s1 <= st1_d;
		end
	end

	hsirgbw_gain_rom u_gain_rom (
		.clk  (clk),
		.en   (en2),
		.addr (st1_s1.offset),
		.data (gain_s2)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			sector_s2 <= st1_s1.sector;
			si_s2     <= (hsirgbw_pkg::SI_W)'(st1_s1.sat) * (hsirgbw_pkg::SI_W)'(st1_s1.inten);
			wi_s2     <= (hsirgbw_pkg::SI_W)'(hsirgbw_pkg::ONE - st1_s1.sat) *
				(hsirgbw_pkg::SI_W)'(st1_s1.inten);
		end
	end

	always_comb begin
		st2.sector = sector_s2;
		st2.si     = si_s2;
		st2.wi     = wi_s2;
		st2.gain   = gain_s2;
	end

	hsirgbw_mix u_mix (
		.st2  (st2),
		.rgbw (rgbw_d)
	);

	always_ff @(posedge clk) begin
		if (en3) begin
			drive_s3 <= rgbw_d;
		end
	end

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		color_stall |-> (valid_s1 && valid_s2 && drive_valid && drive_stall))
		else $error("input held off while a stage is free");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (st1_s1.offset < hsirgbw_pkg::SECT_LEN))
		else $error("hue offset outside sector");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (gain_s2 <= hsirgbw_pkg::KONE))
		else $error("gain above unity");

	a_one_dark: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> (drive.red == '0 || drive.green == '0 || drive.blue == '0))
		else $error("no dark color channel");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the HSI to RGBW converter core.
module testbench;

	localparam int          HALF_PERIOD = 2;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          SETTLE      = 10;
	localparam int          DEPTH       = hsirgbw_pkg::GAIN_DEPTH;
	localparam int          OBITS       = hsirgbw_pkg::OUT_BITS;
	localparam int          KW          = hsirgbw_pkg::K_W;
	localparam logic [63:0] PI_28       = 64'd843314857;
	localparam logic [63:0] FULL_DRIVE  = (64'd1 << OBITS) - 64'd1;
	localparam logic [63:0] UNITY       = 64'd1 << hsirgbw_pkg::FRAC_BITS;
	localparam logic [63:0] GAIN_ONE    = 64'd32768;
	localparam int          PROD_SHIFT  = 2 * hsirgbw_pkg::FRAC_BITS + 15;
	localparam int          LEVEL_SHIFT = 2 * hsirgbw_pkg::FRAC_BITS;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               color_valid = 1'b0;
	logic               color_stall;
	hsirgbw_pkg::hsi_t  color       = '0;
	logic               drive_valid;
	logic               drive_stall = 1'b0;
	hsirgbw_pkg::rgbw_t drive;

	logic [KW-1:0]      gain_rom [DEPTH];
	hsirgbw_pkg::rgbw_t pending_drive [$];
	int                 mismatches = 0;
	int                 cycles     = 0;
	int                 stall_left = 0;
	bit                 src_idle   = 1'b1;
	bit                 sink_idle  = 1'b1;

	hsi_to_rgbw_converter_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.color_valid(color_valid),
		.color_stall(color_stall),
		.color      (color),
		.drive_valid(drive_valid),
		.drive_stall(drive_stall),
		.drive      (drive)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic longint cos_tenths(input logic [63:0] a);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      acc;
		int          k;
		x    = (a * PI_28 + 64'd900) / 64'd1800;
		x2   = (x * x) >> 28;
		term = 64'd1 << 28;
		acc  = longint'(term);
		for (k = 1; k <= 10; k++) begin
			term = ((term * x2) >> 28) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		return acc;
	endfunction

	function automatic logic [KW-1:0] gain_for(input int off);
		longint      lead_c;
		longint      mirror_c;
		longint      total;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] q;
		int          mirror;
		mirror   = (off <= DEPTH / 2) ? (DEPTH / 2 - off) : (off - DEPTH / 2);
		lead_c   = cos_tenths(64'(off));
		mirror_c = cos_tenths(64'(mirror));
		total    = lead_c + mirror_c;
		if (total < 0)
			total = 0;
		if (mirror_c < 1)
			mirror_c = 1;
		den = 64'd3 * 64'(mirror_c);
		num = (64'(total) << 15) + den / 64'd2;
		q   = num / den;
		return (q > GAIN_ONE) ? KW'(GAIN_ONE) : q[KW-1:0];
	endfunction

	function automatic hsirgbw_pkg::rgbw_t rgbw_for(input hsirgbw_pkg::hsi_t c);
		logic [63:0]        h;
		logic [63:0]        s;
		logic [63:0]        i;
		logic [63:0]        si;
		logic [63:0]        lead;
		logic [63:0]        trail;
		logic [63:0]        wht;
		logic [KW-1:0]      k;
		hsirgbw_pkg::rgbw_t r;
		h = 64'(c.hue) % 64'(hsirgbw_pkg::HUE_FULL);
		s = 64'(c.saturation);
		i = 64'(c.intensity);
		if (s > UNITY)
			s = UNITY;
		if (i > UNITY)
			i = UNITY;
		k     = gain_rom[h % 64'(DEPTH)];
		si    = s * i * FULL_DRIVE;
		lead  = (si * 64'(k)) >> PROD_SHIFT;
		trail = (si * (GAIN_ONE - 64'(k))) >> PROD_SHIFT;
		wht   = ((UNITY - s) * i * FULL_DRIVE) >> LEVEL_SHIFT;
		r       = '0;
		r.white = wht[OBITS-1:0];
		case (hsirgbw_pkg::sector_t'(h / 64'(DEPTH)))
			hsirgbw_pkg::SEC_RG: begin
				r.red   = lead[OBITS-1:0];
				r.green = trail[OBITS-1:0];
			end
			hsirgbw_pkg::SEC_GB: begin
				r.green = lead[OBITS-1:0];
				r.blue  = trail[OBITS-1:0];
			end
			default: begin
				r.blue = lead[OBITS-1:0];
				r.red  = trail[OBITS-1:0];
			end
		endcase
		return r;
	endfunction

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic hsirgbw_pkg::hsi_t mk_color(input int hue, input int sat,
			input int inten);
		hsirgbw_pkg::hsi_t c;
		c.hue        = hsirgbw_pkg::HUE_W'(hue);
		c.saturation = hsirgbw_pkg::SI_IN_W'(sat);
		c.intensity  = hsirgbw_pkg::SI_IN_W'(inten);
		return c;
	endfunction

	function automatic int rand_level();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $urandom_range(0, 4096);
		if (r < 8)
			return $urandom_range(0, 8191);
		return $urandom_range(4090, 4100);
	endfunction

	task automatic check_level(input string field, input logic [OBITS-1:0] want,
			input logic [OBITS-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		hsirgbw_pkg::rgbw_t want;
		if (arst_n && color_valid && !color_stall)
			pending_drive.push_back(rgbw_for(color));
		if (arst_n && drive_valid && !drive_stall) begin
			if (pending_drive.size() == 0) begin
				$error("drive level with no request outstanding");
				mismatches++;
			end else begin
				want = pending_drive.pop_front();
				check_level("red", want.red, drive.red);
				check_level("green", want.green, drive.green);
				check_level("blue", want.blue, drive.blue);
				check_level("white", want.white, drive.white);
			end
		end
	end

	always @(posedge clk) begin
		int n;
		if (stall_left > 0) begin
			stall_left--;
			drive_stall <= 1'b1;
		end else begin
			n           = sink_idle ? idle_span() : 0;
			drive_stall <= (n > 0);
			stall_left  = (n > 0) ? n - 1 : 0;
		end
	end

	task automatic send_color(input hsirgbw_pkg::hsi_t c);
		int gap;
		gap = src_idle ? idle_span() : 0;
		if (gap > 0) begin
			color_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		color       <= c;
		color_valid <= 1'b1;
		// hold the request until taken
		do @(posedge clk); while (color_stall);
	endtask

	task automatic drain_drive();
		color_valid <= 1'b0;
		do @(posedge clk); while (pending_drive.size() != 0);
	endtask

	task automatic test_sector_edges();
		int hues [12] = '{0, 1, 599, 600, 1199, 1200, 1800, 2399, 2400, 3000, 3599, 3600};
		foreach (hues[n])
			send_color(mk_color(hues[n], 4096, 4096));
	endtask

	task automatic test_clamp_and_zero();
		send_color(mk_color(65535, 8191, 8191));
		send_color(mk_color(3601, 4097, 4097));
		send_color(mk_color(7199, 0, 4096));
		send_color(mk_color(1000, 4096, 0));
		send_color(mk_color(2000, 0, 0));
		send_color(mk_color(65535, 0, 8191));
		send_color(mk_color(0, 2048, 2048));
		send_color(mk_color(5000, 6000, 4095));
		send_color(mk_color(46800, 8191, 1));
		send_color(mk_color(900, 1, 8191));
	endtask

	task automatic test_random_mixed(input int count);
		repeat (count)
			send_color(mk_color($urandom_range(0, 65535), rand_level(), rand_level()));
	endtask

	task automatic test_back_to_back(input int count);
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		repeat (count)
			send_color(mk_color($urandom_range(0, 65535), $urandom_range(0, 8191),
				$urandom_range(0, 8191)));
		src_idle  = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_near_sector_edges(input int count);
		int hue;
		repeat (count) begin
			// step across sector and wrap boundaries, including wrap below zero
			hue = $urandom_range(0, 54) * DEPTH + $urandom_range(0, 6) - 3;
			send_color(mk_color(hue, rand_level(), rand_level()));
		end
	endtask

	initial begin
		for (int d = 0; d < DEPTH; d++)
			gain_rom[d] = gain_for(d);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sector_edges();
		test_clamp_and_zero();
		drain_drive();
		test_random_mixed(900);
		drain_drive();
		test_back_to_back(500);
		test_near_sector_edges(600);
		drain_drive();

		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
